[design/lfuo_pkg.sv]
// ----------------------------------------------------------------------------
// lfuo_pkg
// Shared types and constants of the least-frequently-used table: channel
// widths, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lfuo_pkg;

   localparam int REQ_DATA_W = 16;   // key
   localparam int RSP_DATA_W = 24;   // hit, evicted_valid, evicted_key, occupancy, pad
   localparam int CSR_DATA_W = 5;    // slots_in_use
   localparam int OUT_KEY_W  = 16;
   localparam int OUT_OCC_W  = 5;
   localparam logic [CSR_DATA_W-1:0] SLOTS_IN_USE_RESET = 5'd16;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_BUMP,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } state_type;

   // Datapath operations
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_SCAN,
      DP_BUMP,
      DP_SHIFT,
      DP_APPEND,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic evict_needed;
      logic shift_done;
      logic out_free;
   } status_type;

endpackage

[design/lfuo_ram.sv]
// ----------------------------------------------------------------------------
// lfuo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfuo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/lfuo_ctrl.sv]
// ----------------------------------------------------------------------------
// lfuo_ctrl
// Sequencer of the table: accepts a key, runs the match/least-count scan,
// then a count bump, or an append (after an eviction shift when the table
// is full), then hands the result to the output register.
// ----------------------------------------------------------------------------
module lfuo_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output lfuo_pkg::cmd_type    cmd,
   input  lfuo_pkg::status_type stat
);

   lfuo_pkg::state_type state_ff;
   lfuo_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfuo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfuo_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lfuo_pkg::ST_SCAN;
         end
         lfuo_pkg::ST_SCAN: begin
            if (stat.scan_done) begin
               if (stat.found)             state_in = lfuo_pkg::ST_BUMP;
               else if (stat.evict_needed) state_in = lfuo_pkg::ST_SHIFT;
               else                        state_in = lfuo_pkg::ST_APPEND;
            end
         end
         lfuo_pkg::ST_BUMP:   state_in = lfuo_pkg::ST_DONE;
         lfuo_pkg::ST_SHIFT: begin
            if (stat.shift_done) state_in = lfuo_pkg::ST_APPEND;
         end
         lfuo_pkg::ST_APPEND: state_in = lfuo_pkg::ST_DONE;
         lfuo_pkg::ST_DONE: begin
            if (stat.out_free) state_in = lfuo_pkg::ST_IDLE;
         end
         default:             state_in = lfuo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op     = lfuo_pkg::DP_NOP;
      req_tready = 1'b0;
      case (state_ff)
         lfuo_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = lfuo_pkg::DP_LOAD;
         end
         lfuo_pkg::ST_SCAN:   cmd.op = lfuo_pkg::DP_SCAN;
         lfuo_pkg::ST_BUMP:   cmd.op = lfuo_pkg::DP_BUMP;
         lfuo_pkg::ST_SHIFT:  cmd.op = lfuo_pkg::DP_SHIFT;
         lfuo_pkg::ST_APPEND: cmd.op = lfuo_pkg::DP_APPEND;
         lfuo_pkg::ST_DONE: begin
            if (stat.out_free) cmd.op = lfuo_pkg::DP_PUBLISH;
         end
         default:             cmd.op = lfuo_pkg::DP_NOP;
      endcase
   end

   // A bump and an eviction never follow the same scan
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfuo_pkg::ST_SCAN && stat.scan_done && stat.found)
         |=> (state_ff == lfuo_pkg::ST_BUMP))
      else $error("hit scan did not go to bump");

   a_shift_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lfuo_pkg::ST_SHIFT && stat.shift_done) |=> (state_ff == lfuo_pkg::ST_APPEND))
      else $error("eviction did not end in append");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == lfuo_pkg::ST_SCAN))
      else $error("accepted key did not start a scan");

endmodule

[design/lfuo_dp.sv]
// ----------------------------------------------------------------------------
// lfuo_dp
// Datapath of the table: entry RAM, occupancy and limit registers, scan
// pointers with match and least-count tracking, shift pointers and the
// result register.
// ----------------------------------------------------------------------------
module lfuo_dp #(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lfuo_pkg::cmd_type                   cmd,
   output lfuo_pkg::status_type                stat,
   input  logic [lfuo_pkg::REQ_DATA_W-1:0]     req_key,
   input  logic                                csr_valid,
   input  logic [lfuo_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic                                rsp_hit,
   output logic                                rsp_evicted_valid,
   output logic [lfuo_pkg::OUT_KEY_W-1:0]      rsp_evicted_key,
   output logic [lfuo_pkg::OUT_OCC_W-1:0]      rsp_occupancy
);

   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENT_W = KEY_BITS + COUNT_BITS;

   // configuration and occupancy
   logic [lfuo_pkg::CSR_DATA_W-1:0] slots_in_use_ff;
   logic [CNT_W-1:0]                total_ff;
   logic [CNT_W-1:0]                limit;

   // scan
   logic [KEY_BITS-1:0]   key_ff;
   logic [CNT_W-1:0]      scan_ptr_ff;
   logic                  cmp_pend_ff;
   logic [AW-1:0]         cmp_idx_ff;
   logic                  found_ff;
   logic [AW-1:0]         match_idx_ff;
   logic [COUNT_BITS-1:0] match_count_ff;
   logic [AW-1:0]         min_idx_ff;
   logic [COUNT_BITS-1:0] min_count_ff;
   logic [KEY_BITS-1:0]   min_key_ff;
   logic                  ev_valid_ff;

   // shift
   logic [CNT_W-1:0] shift_ptr_ff;
   logic             sh_pend_ff;
   logic [AW-1:0]    sh_idx_ff;

   // result register
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic                            rsp_ev_valid_ff;
   logic [lfuo_pkg::OUT_KEY_W-1:0]  rsp_ev_key_ff;
   logic [lfuo_pkg::OUT_OCC_W-1:0]  rsp_occ_ff;

   // RAM
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [ENT_W-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [ENT_W-1:0] ram_rdata;

   logic [KEY_BITS-1:0]   rd_key;
   logic [COUNT_BITS-1:0] rd_count;
   logic                  scan_done;
   logic                  shift_done;

   lfuo_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_key   = ram_rdata[ENT_W-1 -: KEY_BITS];
   assign rd_count = ram_rdata[COUNT_BITS-1:0];

   always_comb begin
      if (slots_in_use_ff == '0) begin
         limit = CNT_W'(1);
      end else if (32'(slots_in_use_ff) > 32'(SLOTS)) begin
         limit = CNT_W'(SLOTS);
      end else begin
         limit = CNT_W'(slots_in_use_ff);
      end
   end

   assign scan_done  = (scan_ptr_ff == total_ff) && !cmp_pend_ff;
   assign shift_done = (shift_ptr_ff == total_ff) && !sh_pend_ff;

   assign stat.scan_done    = scan_done;
   assign stat.found        = found_ff;
   assign stat.evict_needed = (total_ff >= limit) && (total_ff != '0);
   assign stat.shift_done   = shift_done;
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      ram_raddr = scan_ptr_ff[AW-1:0];
      if (cmd.op == lfuo_pkg::DP_SHIFT) ram_raddr = shift_ptr_ff[AW-1:0];
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = total_ff[AW-1:0];
      ram_wdata = {key_ff, COUNT_BITS'(1)};
      case (cmd.op)
         lfuo_pkg::DP_BUMP: begin
            ram_we    = 1'b1;
            ram_waddr = match_idx_ff;
            // saturate at the largest count
            ram_wdata = {key_ff, (&match_count_ff) ? match_count_ff
                                                   : match_count_ff + COUNT_BITS'(1)};
         end
         lfuo_pkg::DP_SHIFT: begin
            // move the entry read last cycle one slot down
            ram_we    = sh_pend_ff;
            ram_waddr = sh_idx_ff - AW'(1);
            ram_wdata = ram_rdata;
         end
         lfuo_pkg::DP_APPEND: begin
            ram_we    = 1'b1;
            ram_waddr = total_ff[AW-1:0];
            ram_wdata = {key_ff, COUNT_BITS'(1)};
         end
         default: ram_we = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= lfuo_pkg::SLOTS_IN_USE_RESET;
         total_ff        <= '0;
         cmp_pend_ff     <= 1'b0;
         sh_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) slots_in_use_ff <= csr_wdata;

         if (cmd.op == lfuo_pkg::DP_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (cmd.op)
            lfuo_pkg::DP_LOAD: begin
               cmp_pend_ff <= 1'b0;
            end
            lfuo_pkg::DP_SCAN: begin
               cmp_pend_ff <= (scan_ptr_ff != total_ff);
            end
            lfuo_pkg::DP_SHIFT: begin
               sh_pend_ff <= (shift_ptr_ff != total_ff);
               if (shift_done) total_ff <= total_ff - CNT_W'(1);
            end
            lfuo_pkg::DP_APPEND: begin
               total_ff <= total_ff + CNT_W'(1);
            end
            lfuo_pkg::DP_PUBLISH: begin
            end
            default: begin
               sh_pend_ff <= 1'b0;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         lfuo_pkg::DP_LOAD: begin
            key_ff      <= KEY_BITS'(req_key);
            scan_ptr_ff <= '0;
            found_ff    <= 1'b0;
            ev_valid_ff <= 1'b0;
         end
         lfuo_pkg::DP_SCAN: begin
            if (scan_ptr_ff != total_ff) begin
               scan_ptr_ff <= scan_ptr_ff + CNT_W'(1);
               cmp_idx_ff  <= scan_ptr_ff[AW-1:0];
            end
            if (cmp_pend_ff) begin
               if (!found_ff && rd_key == key_ff) begin
                  found_ff       <= 1'b1;
                  match_idx_ff   <= cmp_idx_ff;
                  match_count_ff <= rd_count;
               end
               // strict less-than keeps the oldest on a tie
               if (cmp_idx_ff == '0 || rd_count < min_count_ff) begin
                  min_idx_ff   <= cmp_idx_ff;
                  min_count_ff <= rd_count;
                  min_key_ff   <= rd_key;
               end
            end
            if (scan_done) shift_ptr_ff <= CNT_W'(min_idx_ff) + CNT_W'(1);
         end
         lfuo_pkg::DP_SHIFT: begin
            if (shift_ptr_ff != total_ff) begin
               shift_ptr_ff <= shift_ptr_ff + CNT_W'(1);
               sh_idx_ff    <= shift_ptr_ff[AW-1:0];
            end
            if (shift_done) ev_valid_ff <= 1'b1;
         end
         lfuo_pkg::DP_PUBLISH: begin
            rsp_hit_ff      <= found_ff;
            rsp_ev_valid_ff <= ev_valid_ff;
            rsp_ev_key_ff   <= ev_valid_ff ? lfuo_pkg::OUT_KEY_W'(min_key_ff) : '0;
            rsp_occ_ff      <= lfuo_pkg::OUT_OCC_W'(total_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_key   = rsp_ev_key_ff;
   assign rsp_occupancy     = rsp_occ_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(SLOTS))
      else $error("occupancy above table size");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CNT_W'(ram_waddr) <= total_ff))
      else $error("entry write beyond the occupied range");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_valid_ff))
      else $error("result shows both a hit and an eviction");

   a_publish: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == lfuo_pkg::DP_PUBLISH) |=> rsp_valid_ff)
      else $error("published result not presented");

endmodule

[design/lfu_table_oldest_tiebreak_top.sv]
// ----------------------------------------------------------------------------
// lfu_table_oldest_tiebreak_top
// Least-frequently-used key table with oldest-first tie break.
// ----------------------------------------------------------------------------
// Each key on the request stream is looked up in a table of up to
// slots_in_use entries (zero acts as one, capped at SLOTS) kept in insertion
// order. A hit bumps that entry's count (saturating); a miss on a full table
// evicts the entry with the least count (the oldest among equals), closes the
// gap and appends the new key with count 1. One response per key. The entries
// sit in a single-write, single-read RAM read one entry per cycle during the
// scan, and an eviction shifts the entries above the victim one slot down.
// The response sits in an output register; the next key is taken once the
// previous result is in it. csr writes are to be made only when idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module lfu_table_oldest_tiebreak_top #(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lfuo_pkg::REQ_DATA_W-1:0]   req_tdata,  // [15:0] key
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] hit, [1] evicted_valid, [17:2] evicted_key, [22:18] occupancy, [23] zero
   output logic [lfuo_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lfuo_pkg::CSR_DATA_W-1:0]   csr_wdata   // slots_in_use
);

   lfuo_pkg::cmd_type    cmd;
   lfuo_pkg::status_type stat;

   logic                           rsp_hit;
   logic                           rsp_evicted_valid;
   logic [lfuo_pkg::OUT_KEY_W-1:0] rsp_evicted_key;
   logic [lfuo_pkg::OUT_OCC_W-1:0] rsp_occupancy;

   assign csr_ready = 1'b1;

   lfuo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   lfuo_dp #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_key           (req_tdata),
      .csr_valid         (csr_valid),
      .csr_wdata         (csr_wdata),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_occupancy     (rsp_occupancy)
   );

   assign rsp_tdata = {1'b0, rsp_occupancy, rsp_evicted_key, rsp_evicted_valid, rsp_hit};

endmodule

[tb/lfu_table_checker.sv]
// ----------------------------------------------------------------------------
// lfu_table_checker
// Watches the key, response and csr channels of the LFU table, keeps its own
// copy of the table, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module lfu_table_checker #(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lfuo_pkg::REQ_DATA_W-1:0] req_tdata,   // [15:0] key
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] hit, [1] evicted_valid, [17:2] evicted_key, [22:18] occupancy, [23] zero
   input  logic [lfuo_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [lfuo_pkg::CSR_DATA_W-1:0] csr_wdata,   // slots_in_use
   output int                              mismatch_total,
   output int                              lookups_in_flight
);

   typedef struct packed {
      logic                           hit;
      logic                           evicted_valid;
      logic [lfuo_pkg::OUT_KEY_W-1:0] evicted_key;
      logic [lfuo_pkg::OUT_OCC_W-1:0] occupancy;
   } lookup_result_type;

   logic [KEY_BITS-1:0]             table_key [SLOTS];
   logic [COUNT_BITS-1:0]           table_count [SLOTS];
   int                              table_fill;
   logic [lfuo_pkg::CSR_DATA_W-1:0] slot_limit;
   lookup_result_type               expected_lookups [$];
   lookup_result_type               predicted;
   lookup_result_type               oldest;
   int                              responses_seen;

   function automatic int effective_limit();
      if (slot_limit == '0) return 1;
      if (int'(slot_limit) > SLOTS) return SLOTS;
      return int'(slot_limit);
   endfunction

   // Look the key up, update the table copy and return the response it causes.
   task automatic lookup_and_update(input logic [KEY_BITS-1:0] key,
                                    output lookup_result_type result);
      int                    pos;
      int                    victim;
      logic [COUNT_BITS-1:0] least;
      result = '0;
      pos = -1;
      for (int i = 0; i < table_fill; i++) begin
         if (pos < 0 && table_key[i] == key) pos = i;
      end
      if (pos >= 0) begin
         result.hit = 1'b1;
         // saturate at the largest count
         if (table_count[pos] != '1) table_count[pos] = table_count[pos] + 1'b1;
      end else begin
         if (table_fill >= effective_limit() && table_fill > 0) begin
            // least count wins, the oldest among equals
            victim = 0;
            least = table_count[0];
            for (int i = 1; i < table_fill; i++) begin
               if (table_count[i] < least) begin
                  least = table_count[i];
                  victim = i;
               end
            end
            result.evicted_valid = 1'b1;
            result.evicted_key = lfuo_pkg::OUT_KEY_W'(table_key[victim]);
            for (int i = victim; i + 1 < table_fill; i++) begin
               table_key[i] = table_key[i+1];
               table_count[i] = table_count[i+1];
            end
            table_fill--;
         end
         if (table_fill < SLOTS) begin
            table_key[table_fill] = key;
            table_count[table_fill] = COUNT_BITS'(1);
            table_fill++;
         end
      end
      result.occupancy = lfuo_pkg::OUT_OCC_W'(table_fill);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_total < 40) begin
         $display("mismatch on response %0d: %s expected 0x%0h got 0x%0h",
                  responses_seen, what, want, got);
      end
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         table_fill = 0;
         slot_limit = lfuo_pkg::SLOTS_IN_USE_RESET;
         expected_lookups.delete();
         mismatch_total = 0;
         responses_seen = 0;
      end else begin
         if (csr_valid && csr_ready) slot_limit = csr_wdata;
         if (req_tvalid && req_tready) begin
            lookup_and_update(req_tdata[KEY_BITS-1:0], predicted);
            expected_lookups.insert(expected_lookups.size(), predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("response with no lookup pending", '0, 32'(rsp_tdata));
            end else begin
               oldest = expected_lookups.pop_front();
               if (rsp_tdata[0] !== oldest.hit)
                  report_mismatch("hit", 32'(oldest.hit), 32'(rsp_tdata[0]));
               if (rsp_tdata[1] !== oldest.evicted_valid)
                  report_mismatch("evicted_valid", 32'(oldest.evicted_valid),
                                  32'(rsp_tdata[1]));
               if (rsp_tdata[17:2] !== oldest.evicted_key)
                  report_mismatch("evicted_key", 32'(oldest.evicted_key),
                                  32'(rsp_tdata[17:2]));
               if (rsp_tdata[22:18] !== oldest.occupancy)
                  report_mismatch("occupancy", 32'(oldest.occupancy),
                                  32'(rsp_tdata[22:18]));
               if (rsp_tdata[23] !== 1'b0)
                  report_mismatch("pad bit", '0, 32'(rsp_tdata[23]));
            end
            responses_seen++;
         end
      end
      lookups_in_flight <= expected_lookups.size();
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the LFU table with oldest-first tie break.
// Drives a run of repeated hits on one entry, a directed set of eviction and
// limit cases and random key streams under several slot limits, with random
// gaps and backpressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 200_000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [lfuo_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [lfuo_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lfuo_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            steady = 1'b0;
   int                              mismatch_total;
   int                              lookups_in_flight;
   int                              cycle_count = 0;

   always #2 clock = ~clock;

   lfu_table_oldest_tiebreak_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   lfu_table_checker table_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .mismatch_total    (mismatch_total),
      .lookups_in_flight (lookups_in_flight)
   );

   // stall the response side 28 percent of the time unless steady
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic send_key(input logic [lfuo_pkg::REQ_DATA_W-1:0] key);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off new keys until every response has come back
   task automatic drain_lookups();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lookups_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [lfuo_pkg::CSR_DATA_W-1:0] limit);
      drain_lookups();
      csr_valid <= 1'b1;
      csr_wdata <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [lfuo_pkg::REQ_DATA_W-1:0] key_pool [24];
      int                              phase_limit [5];
      int                              pool_size;
      int                              pick_a;
      int                              pick_b;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // repeated hits on one entry, no idling
      steady <= 1'b1;
      write_slot_limit(5'd1);
      repeat (12) send_key(16'h0000);
      steady <= 1'b0;

      // fill four slots, then evict with ties and a shift
      write_slot_limit(5'd4);
      send_key(16'hFFFF);
      send_key(16'h1234);
      send_key(16'h8001);
      send_key(16'hFFFF);
      send_key(16'h5555);
      send_key(16'h8001);
      send_key(16'h5555);
      send_key(16'h8001);
      send_key(16'h2AAA);

      // limit of zero acts as one and sits below occupancy
      write_slot_limit(5'd0);
      send_key(16'h00FF);
      send_key(16'h00FF);

      // limit above the table size acts as the table size
      write_slot_limit(5'd31);
      send_key(16'h4000);
      send_key(16'h0001);
      send_key(16'h7FFF);
      send_key(16'h8000);
      write_slot_limit(5'd17);
      send_key(16'hC3C3);

      phase_limit[0] = 16;
      phase_limit[1] = 2;
      phase_limit[2] = 31;
      phase_limit[3] = 1;
      phase_limit[4] = $urandom_range(0, 31);
      for (int phase = 0; phase < 5; phase++) begin
         write_slot_limit(lfuo_pkg::CSR_DATA_W'(phase_limit[phase]));
         steady <= (phase == 2);
         pool_size = $urandom_range(4, 24);
         for (int i = 0; i < 24; i++) begin
            key_pool[i] = lfuo_pkg::REQ_DATA_W'($urandom_range(0, 65535));
         end
         for (int n = 0; n < 95; n++) begin
            if (n == 50) drain_lookups();
            if ($urandom_range(99) < 75) begin
               // skew toward the low pool entries so counts spread out
               pick_a = $urandom_range(0, pool_size - 1);
               pick_b = $urandom_range(0, pool_size - 1);
               send_key(key_pool[(pick_a < pick_b) ? pick_a : pick_b]);
            end else begin
               send_key(lfuo_pkg::REQ_DATA_W'($urandom_range(0, 65535)));
            end
         end
      end

      drain_lookups();
      repeat (40) @(posedge clock);
      if (mismatch_total == 0 && lookups_in_flight == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

[lfu_table_oldest_tiebreak_top.f]
design/lfuo_pkg.sv
design/lfuo_ram.sv
design/lfuo_ctrl.sv
design/lfuo_dp.sv
design/lfu_table_oldest_tiebreak_top.sv
tb/lfu_table_checker.sv
tb/testbench.sv
